FILE: src/bdc_pkg.sv
// shared types and constants for the button debounce and click detector
`timescale 1ns / 1ps
package bdc_pkg;

	localparam int BUTTON_COUNT = 8;
	localparam int BTN_BITS = $clog2(BUTTON_COUNT);
	localparam int TIME_BITS = 32;
	localparam int MAX_EVENTS = 3;
	localparam int CNT_BITS = $clog2(MAX_EVENTS + 1);
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 16;

	typedef logic [BTN_BITS-1:0] btn_idx_t;
	typedef logic [TIME_BITS-1:0] time_t;
	typedef logic [CNT_BITS-1:0] ev_cnt_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_DEBOUNCE     = 3'd0,
		REG_LONG_PRESS   = 3'd1,
		REG_DOUBLE_CLICK = 3'd2,
		REG_ACTIVE_LOW   = 3'd3,
		REG_ENABLE       = 3'd4
	} cfg_reg_t;

	// event codes
	typedef enum logic [2:0] {
		EV_PRESSED  = 3'd0,
		EV_RELEASED = 3'd1,
		EV_CLICK    = 3'd2,
		EV_DOUBLE   = 3'd3,
		EV_LONG     = 3'd4
	} event_kind_t;

	// per-button state word held in the state memory
	typedef struct packed {
		logic  stable_pressed;
		logic  change_pending;
		time_t change_start_ms;
		time_t press_start_ms;
		time_t release_at_ms;
		logic  long_reported;
		logic  click_pending;
	} btn_state_t;

endpackage

FILE: src/bdc_state_ram.sv
// per-button state memory with registered read and per-entry valid bits
`timescale 1ns / 1ps
module bdc_state_ram (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  bdc_pkg::btn_idx_t   rd_addr,
	output bdc_pkg::btn_state_t rd_data,
	input  logic                wr_en,
	input  bdc_pkg::btn_idx_t   wr_addr,
	input  bdc_pkg::btn_state_t wr_data
);
	import bdc_pkg::*;

	btn_state_t                mem [BUTTON_COUNT];
	btn_state_t                rd_q;
	logic [BUTTON_COUNT-1:0]   vld_q;
	logic                      rd_vld_q;

	// storage array, read-old on a same-cycle collision
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// entry valid bits, an unwritten entry reads as the reset state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

FILE: src/button_debounce_click_detector_core.sv
// Debounce and click detection for up to eight buttons polled through one
// port. An accepted poll reads its button's state word from the state memory
// in the next cycle, is evaluated and written back when the evaluation stage
// fires, and leaves its zero to three events in a small event register that
// sends one event per cycle while out_ready is high. A poll is taken every
// cycle while the event register is empty or holds only its last event and
// out_ready is high. Back-to-back polls of the same button are forwarded
// around the memory. Times wrap modulo 2^32.
`timescale 1ns / 1ps
module button_debounce_click_detector_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// poll channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  bdc_pkg::btn_idx_t                   button_index,
	input  logic                                raw_level,
	input  bdc_pkg::time_t                      now_ms,
	// event channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output bdc_pkg::btn_idx_t                   event_button,
	output logic [2:0]                          event_kind,
	output logic                                last_event,
	// configuration
	input  logic                                cfg_we,
	input  logic [bdc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [bdc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
	import bdc_pkg::*;

	logic [9:0]              debounce_q;
	logic [15:0]             long_press_q;
	logic [15:0]             double_click_q;
	logic [BUTTON_COUNT-1:0] active_low_q;
	logic [BUTTON_COUNT-1:0] enable_q;

	logic                   valid_s1;
	btn_idx_t               btn_s1;
	logic                   lvl_s1;
	time_t                  now_s1;

	logic                   fwd_hit_q;
	btn_state_t             fwd_data_q;

	event_kind_t            ev_q [MAX_EVENTS];
	ev_cnt_t                ev_cnt_q;
	btn_idx_t               ev_btn_q;

	btn_state_t             rd_data;
	btn_state_t             cur;
	btn_state_t             nxt;
	event_kind_t            ev_new [MAX_EVENTS];
	ev_cnt_t                n_new;
	logic                   pressed;
	logic                   enabled;
	logic                   fire;
	logic                   accept;
	logic                   pop;
	logic                   wr_en;
	time_t                  held;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q     <= 10'd50;
			long_press_q   <= 16'd1000;
			double_click_q <= 16'd300;
			active_low_q   <= '1;
			enable_q       <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEBOUNCE:     debounce_q     <= cfg_data[9:0];
				REG_LONG_PRESS:   long_press_q   <= cfg_data[15:0];
				REG_DOUBLE_CLICK: double_click_q <= cfg_data[15:0];
				REG_ACTIVE_LOW:   active_low_q   <= cfg_data[BUTTON_COUNT-1:0];
				REG_ENABLE:       enable_q       <= cfg_data[BUTTON_COUNT-1:0];
				default: ;
			endcase
		end
	end

	// handshake and stage control
	assign pop      = out_valid && out_ready;
	assign fire     = valid_s1 && ((ev_cnt_q == '0) || ((ev_cnt_q == ev_cnt_t'(1)) && out_ready));
	assign in_ready = !valid_s1 || fire;
	assign accept   = in_valid && in_ready;
	assign enabled  = enable_q[btn_s1];
	assign wr_en    = fire && enabled;

	// state memory
	bdc_state_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (button_index),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (btn_s1),
		.wr_data (nxt)
	);

	// evaluation stage registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			fwd_hit_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1  <= 1'b1;
				fwd_hit_q <= wr_en && (btn_s1 == button_index);
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			btn_s1     <= button_index;
			lvl_s1     <= raw_level;
			now_s1     <= now_ms;
			fwd_data_q <= nxt;
		end
	end

	// read-modify-write of one button's state
	always_comb begin
		cur     = fwd_hit_q ? fwd_data_q : rd_data;
		nxt     = cur;
		n_new   = '0;
		held    = now_s1 - cur.press_start_ms;
		for (int i = 0; i < MAX_EVENTS; i++) begin
			ev_new[i] = EV_PRESSED;
		end
		pressed = active_low_q[btn_s1] ? !lvl_s1 : lvl_s1;

		// double-click window expiry
		if (cur.click_pending &&
		    ((now_s1 - cur.release_at_ms) > time_t'(double_click_q))) begin
			nxt.click_pending = 1'b0;
			ev_new[n_new]     = EV_CLICK;
			n_new             = n_new + ev_cnt_t'(1);
		end

		// debounce
		if (pressed != cur.stable_pressed) begin
			if (!cur.change_pending) begin
				nxt.change_pending  = 1'b1;
				nxt.change_start_ms = now_s1;
			end
			if ((now_s1 - nxt.change_start_ms) >= time_t'(debounce_q)) begin
				nxt.change_pending = 1'b0;
				nxt.stable_pressed = pressed;
				if (pressed) begin
					nxt.press_start_ms = now_s1;
					nxt.long_reported  = 1'b0;
					ev_new[n_new]      = EV_PRESSED;
					n_new              = n_new + ev_cnt_t'(1);
				end else begin
					nxt.release_at_ms = now_s1;
					ev_new[n_new]     = EV_RELEASED;
					n_new             = n_new + ev_cnt_t'(1);
					if (!cur.long_reported && (held < time_t'(long_press_q))) begin
						if (nxt.click_pending) begin
							nxt.click_pending = 1'b0;
							ev_new[n_new]     = EV_DOUBLE;
							n_new             = n_new + ev_cnt_t'(1);
						end else begin
							nxt.click_pending = 1'b1;
						end
					end
				end
			end
		end else begin
			nxt.change_pending = 1'b0;
		end

		// long press
		if (nxt.stable_pressed && !nxt.long_reported &&
		    ((now_s1 - nxt.press_start_ms) >= time_t'(long_press_q))) begin
			nxt.long_reported = 1'b1;
			ev_new[n_new]     = EV_LONG;
			n_new             = n_new + ev_cnt_t'(1);
		end
	end

	// event register, drained one item per cycle while out_ready is high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_cnt_q <= '0;
		end else if (fire && enabled && (n_new != '0)) begin
			ev_cnt_q <= n_new;
		end else if (pop) begin
			ev_cnt_q <= ev_cnt_q - ev_cnt_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (fire && enabled && (n_new != '0)) begin
			ev_btn_q <= btn_s1;
			for (int i = 0; i < MAX_EVENTS; i++) begin
				ev_q[i] <= ev_new[i];
			end
		end else if (pop) begin
			for (int i = 0; i < MAX_EVENTS - 1; i++) begin
				ev_q[i] <= ev_q[i+1];
			end
		end
	end

	// output channel
	assign out_valid    = (ev_cnt_q != '0);
	assign event_button = ev_btn_q;
	assign event_kind   = ev_q[0];
	assign last_event   = (ev_cnt_q == ev_cnt_t'(1));

endmodule

FILE: tb/testbench.sv
// self-checking testbench for the button debounce and click detector core
`timescale 1ns / 1ps
module testbench;
	import bdc_pkg::*;

	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int MAX_REPORTS    = 10;

	// one expected or observed event
	typedef struct {
		btn_idx_t    btn;
		event_kind_t kind;
		logic        last;
	} event_rec_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	btn_idx_t                 button_index = '0;
	logic                     raw_level = 1'b0;
	time_t                    now_ms = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	btn_idx_t                 event_button;
	logic [2:0]               event_kind;
	logic                     last_event;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	// register copies as the block should hold them
	logic [9:0]  m_debounce;
	logic [15:0] m_long;
	logic [15:0] m_dbl;
	logic [7:0]  m_active_low;
	logic [7:0]  m_enable;

	// per-button state of the predictor
	bit    st_pressed  [BUTTON_COUNT];
	bit    st_pending  [BUTTON_COUNT];
	time_t st_change_t [BUTTON_COUNT];
	time_t st_press_t  [BUTTON_COUNT];
	time_t st_release_t[BUTTON_COUNT];
	bit    st_long     [BUTTON_COUNT];
	bit    st_click    [BUTTON_COUNT];

	// stimulus intent per button and shared poll clock
	bit    want_pressed[BUTTON_COUNT];
	time_t clock_ms;

	event_rec_t event_q[$];
	event_rec_t got_ev;
	event_rec_t want_ev;

	int  mismatch_cnt = 0;
	int  polls_sent = 0;
	int  events_seen = 0;
	int  settings_cnt = 0;
	int  kind_cnt[5] = '{default: 0};
	int  quiet_cycles = 0;
	int  sink_hold = 0;
	int  sink_roll;
	bit  gaps_on = 1'b1;
	bit  stalls_on = 1'b1;

	button_debounce_click_detector_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.button_index (button_index),
		.raw_level    (raw_level),
		.now_ms       (now_ms),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.event_button (event_button),
		.event_kind   (event_kind),
		.last_event   (last_event),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// clock
	always #5 clk = ~clk;

	// predictor state after reset
	function automatic void reset_predictor();
		m_debounce   = 10'd50;
		m_long       = 16'd1000;
		m_dbl        = 16'd300;
		m_active_low = 8'hFF;
		m_enable     = 8'h00;
		for (int i = 0; i < BUTTON_COUNT; i++) begin
			st_pressed[i]   = 1'b0;
			st_pending[i]   = 1'b0;
			st_change_t[i]  = '0;
			st_press_t[i]   = '0;
			st_release_t[i] = '0;
			st_long[i]      = 1'b0;
			st_click[i]     = 1'b0;
			want_pressed[i] = 1'b0;
		end
	endfunction

	// expected events of one accepted poll, queued in order
	function automatic void predict_poll(input btn_idx_t b, input logic lvl, input time_t now);
		event_rec_t evs[$];
		event_rec_t e;
		bit         pressed;
		time_t      held;
		if (!m_enable[b])
			return;
		pressed = m_active_low[b] ? (lvl == 1'b0) : (lvl == 1'b1);
		// double-click window runs out
		if (st_click[b] && time_t'(now - st_release_t[b]) > m_dbl) begin
			st_click[b] = 1'b0;
			evs.push_back('{b, EV_CLICK, 1'b0});
		end
		// debounce of a level change
		if (pressed != st_pressed[b]) begin
			if (!st_pending[b]) begin
				st_pending[b]  = 1'b1;
				st_change_t[b] = now;
			end
			if (time_t'(now - st_change_t[b]) >= m_debounce) begin
				st_pending[b] = 1'b0;
				st_pressed[b] = pressed;
				if (pressed) begin
					st_press_t[b] = now;
					st_long[b]    = 1'b0;
					evs.push_back('{b, EV_PRESSED, 1'b0});
				end else begin
					held            = now - st_press_t[b];
					st_release_t[b] = now;
					evs.push_back('{b, EV_RELEASED, 1'b0});
					if (!st_long[b] && held < m_long) begin
						if (st_click[b]) begin
							st_click[b] = 1'b0;
							evs.push_back('{b, EV_DOUBLE, 1'b0});
						end else begin
							st_click[b] = 1'b1;
						end
					end
				end
			end
		end else begin
			st_pending[b] = 1'b0;
		end
		// long press while held
		if (st_pressed[b] && !st_long[b] && time_t'(now - st_press_t[b]) >= m_long) begin
			st_long[b] = 1'b1;
			evs.push_back('{b, EV_LONG, 1'b0});
		end
		for (int i = 0; i < evs.size(); i++) begin
			e      = evs[i];
			e.last = (i == evs.size() - 1);
			event_q.push_back(e);
		end
	endfunction

	function automatic void flag_mismatch(input string what, input bit have_want);
		mismatch_cnt++;
		if (mismatch_cnt <= MAX_REPORTS) begin
			if (have_want)
				$display("%0t: %s: expected btn %0d kind %0d last %0d, got btn %0d kind %0d last %0d",
					$realtime, what, want_ev.btn, want_ev.kind, want_ev.last,
					got_ev.btn, got_ev.kind, got_ev.last);
			else
				$display("%0t: %s: got btn %0d kind %0d last %0d",
					$realtime, what, got_ev.btn, got_ev.kind, got_ev.last);
		end
	endfunction

	// event checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got_ev.btn  = event_button;
			got_ev.kind = event_kind_t'(event_kind);
			got_ev.last = last_event;
			events_seen++;
			if (event_kind < 3'd5)
				kind_cnt[event_kind]++;
			if (event_q.size() == 0) begin
				flag_mismatch("event with none expected", 1'b0);
			end else begin
				want_ev = event_q.pop_front();
				if (event_button !== want_ev.btn || event_kind !== want_ev.kind ||
					last_event !== want_ev.last)
					flag_mismatch("event mismatch", 1'b1);
			end
		end
	end

	// event sink with random back-pressure
	always @(posedge clk) begin
		if (sink_hold > 0) begin
			sink_hold <= sink_hold - 1;
			out_ready <= 1'b0;
		end else begin
			sink_roll = $urandom_range(0, 99);
			if (!stalls_on || sink_roll < 60) begin
				out_ready <= 1'b1;
			end else if (sink_roll < 94) begin
				out_ready <= 1'b0;
				sink_hold <= $urandom_range(0, 2);
			end else begin
				out_ready <= 1'b0;
				sink_hold <= $urandom_range(8, 40);
			end
		end
	end

	// watchdog on cycles without any accepted item
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", quiet_cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		if (!gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// send one poll and predict its events on acceptance
	task automatic send_poll(input btn_idx_t b, input logic lvl, input time_t t);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		button_index <= b;
		raw_level    <= lvl;
		now_ms       <= t;
		do @(posedge clk); while (!in_ready);
		predict_poll(b, lvl, t);
		polls_sent++;
	endtask

	// hold the poll side until every expected event is out, then let the pipe settle
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (event_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			REG_DEBOUNCE:     m_debounce   = data[9:0];
			REG_LONG_PRESS:   m_long       = data[15:0];
			REG_DOUBLE_CLICK: m_dbl        = data[15:0];
			REG_ACTIVE_LOW:   m_active_low = data[7:0];
			REG_ENABLE:       m_enable     = data[7:0];
			default: ;
		endcase
	endtask

	task automatic end_writes();
		cfg_we <= 1'b0;
		@(posedge clk);
		settings_cnt++;
	endtask

	task automatic program_all(input logic [15:0] deb, input logic [15:0] lng,
		input logic [15:0] dbl, input logic [15:0] al, input logic [15:0] en);
		write_reg(REG_DEBOUNCE, deb);
		write_reg(REG_LONG_PRESS, lng);
		write_reg(REG_DOUBLE_CLICK, dbl);
		write_reg(REG_ACTIVE_LOW, al);
		write_reg(REG_ENABLE, en);
		end_writes();
	endtask

	// random polls shaped as press and release sequences with bounce and noise
	task automatic random_phase(input int n, input int step_max);
		int       useful;
		btn_idx_t b;
		bit       p;
		logic     lvl;
		useful = 0;
		while (useful < n) begin
			if (useful % 25 == 0) begin
				gaps_on   = ($urandom_range(0, 3) != 0);
				stalls_on = ($urandom_range(0, 3) != 0);
			end
			if ($urandom_range(0, 99) < 3)
				clock_ms += $urandom();
			else
				clock_ms += $urandom_range(0, step_max);
			b = btn_idx_t'($urandom_range(0, BUTTON_COUNT - 1));
			if ($urandom_range(0, 99) >= 10)
				while (!m_enable[b])
					b = btn_idx_t'($urandom_range(0, BUTTON_COUNT - 1));
			if ($urandom_range(0, 3) == 0)
				want_pressed[b] = !want_pressed[b];
			p   = want_pressed[b] ^ ($urandom_range(0, 9) == 0);
			lvl = m_active_low[b] ? !p : p;
			send_poll(b, lvl, clock_ms);
			if (m_enable[b])
				useful++;
		end
		gaps_on   = 1'b1;
		stalls_on = 1'b1;
	endtask

	// reset values: nothing enabled, then default timing and polarity
	task automatic test_reset_defaults();
		send_poll(3'd0, 1'b0, 32'd100);
		wait_drained();
		write_reg(REG_ENABLE, 16'h0001);
		end_writes();
		send_poll(3'd0, 1'b0, 32'd200);
		send_poll(3'd0, 1'b0, 32'd250);
	endtask

	// debounce with a bounce back, short release, then window expiry
	task automatic test_click_and_bounce();
		wait_drained();
		program_all(16'd10, 16'd100, 16'd50, 16'h000F, 16'h007F);
		send_poll(3'd0, 1'b0, 32'd1000);
		send_poll(3'd0, 1'b1, 32'd1005);
		send_poll(3'd0, 1'b0, 32'd1010);
		send_poll(3'd0, 1'b0, 32'd1020);
		send_poll(3'd0, 1'b1, 32'd1040);
		send_poll(3'd0, 1'b1, 32'd1050);
		send_poll(3'd0, 1'b1, 32'd1120);
	endtask

	// zero debounce, active-high button, two short clicks
	task automatic test_double_click_zero_debounce();
		wait_drained();
		write_reg(REG_DEBOUNCE, 16'd0);
		end_writes();
		send_poll(3'd4, 1'b1, 32'd3000);
		send_poll(3'd4, 1'b0, 32'd3020);
		send_poll(3'd4, 1'b1, 32'd3030);
		send_poll(3'd4, 1'b0, 32'd3040);
	endtask

	// hold past the threshold, release gives only released
	task automatic test_long_press();
		wait_drained();
		write_reg(REG_DEBOUNCE, 16'd10);
		end_writes();
		send_poll(3'd2, 1'b0, 32'd5000);
		send_poll(3'd2, 1'b0, 32'd5010);
		send_poll(3'd2, 1'b0, 32'd5115);
		send_poll(3'd2, 1'b1, 32'd5120);
		send_poll(3'd2, 1'b1, 32'd5130);
	endtask

	// register masking, unused indexes, time wrap, disabled button, three events
	task automatic test_extremes_and_wrap();
		wait_drained();
		for (int i = int'(REG_ENABLE) + 1; i < (1 << CFG_IDX_BITS); i++)
			write_reg(CFG_IDX_BITS'(i), CFG_DATA_BITS'($urandom_range(0, 65535)));
		program_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFF7F);
		send_poll(3'd5, 1'b0, 32'hFFFF_FE00);
		send_poll(3'd5, 1'b0, 32'h0000_01FF);
		send_poll(3'd7, 1'b0, 32'hFFFF_FFFF);
		wait_drained();
		program_all(16'd0, 16'd100, 16'd0, 16'h0000, 16'h0080);
		send_poll(3'd7, 1'b1, 32'd10);
		send_poll(3'd7, 1'b0, 32'd20);
		wait_drained();
		write_reg(REG_LONG_PRESS, 16'd0);
		end_writes();
		// expiry, press and long press from one poll
		send_poll(3'd7, 1'b1, 32'd30);
		send_poll(3'd7, 1'b0, 32'd40);
	endtask

	// lively timing on many buttons, with a full drain in the middle
	task automatic test_random_mixed();
		wait_drained();
		clock_ms = $urandom();
		program_all(16'($urandom_range(0, 15)), 16'($urandom_range(60, 200)),
			16'($urandom_range(40, 150)), 16'($urandom_range(0, 255)),
			16'($urandom_range(0, 255) | (1 << $urandom_range(0, 7))));
		random_phase(25, 8);
		wait_drained();
		random_phase(25, 8);
	endtask

	// same kind of traffic across the 32-bit time wrap
	task automatic test_random_wrap();
		wait_drained();
		clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 1500);
		program_all(16'($urandom_range(0, 15)), 16'($urandom_range(60, 200)),
			16'($urandom_range(40, 150)), 16'($urandom_range(0, 255)),
			16'($urandom_range(0, 255) | (1 << $urandom_range(0, 7))));
		random_phase(40, 8);
	endtask

	// one button in use, dense clicks
	task automatic test_random_single_button();
		wait_drained();
		program_all(16'($urandom_range(0, 10)), 16'($urandom_range(40, 80)),
			16'($urandom_range(30, 80)), 16'($urandom_range(0, 255)),
			16'd1 << $urandom_range(0, 7));
		random_phase(25, 10);
	endtask

	// largest register values, slow polls
	task automatic test_random_slow_extremes();
		wait_drained();
		program_all(16'd1023, 16'hFFFF, 16'hFFFF, 16'($urandom_range(0, 255)), 16'h00FF);
		random_phase(30, 300);
	endtask

	// all times zero: every change lands at once and every press is long
	task automatic test_random_all_zero();
		wait_drained();
		program_all(16'd0, 16'd0, 16'd0, 16'($urandom_range(0, 255)),
			16'($urandom_range(0, 255) | (1 << $urandom_range(0, 7))));
		random_phase(25, 5);
	endtask

	// test sequence
	initial begin
		reset_predictor();
		clock_ms = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_click_and_bounce();
		test_double_click_zero_debounce();
		test_long_press();
		test_extremes_and_wrap();
		test_random_mixed();
		test_random_wrap();
		test_random_single_button();
		test_random_slow_extremes();
		test_random_all_zero();

		wait_drained();
		if (event_q.size() != 0) begin
			$display("%0d expected events never arrived", event_q.size());
			mismatch_cnt += event_q.size();
		end
		$display("covered %0d polls under %0d register settings, %0d events checked",
			polls_sent, settings_cnt, events_seen);
		$display("events seen: pressed %0d, released %0d, click %0d, double %0d, long %0d",
			kind_cnt[0], kind_cnt[1], kind_cnt[2], kind_cnt[3], kind_cnt[4]);
		if (mismatch_cnt == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
